@@ sv/tmrt_pkg.sv @@
// ----------------------------------------------------------------------------
// tmrt_pkg: shared definitions of the triple match/reload timer
// widths, register map, access codes and the timer control/result types
// ----------------------------------------------------------------------------
`default_nettype none

package tmrt_pkg;

	localparam int NUM_TIMERS  = 3;
	localparam int COUNT_WIDTH = 32;
	localparam int REG_W       = 32;
	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 8;
	localparam int IRQ_W       = 3;

	localparam logic [REG_W-1:0]  REVISION_WORD = 32'h0001_0801;
	localparam logic [ADDR_W-1:0] CONTROL_ADDR  = 6'h30;
	localparam logic [ADDR_W-1:0] STATUS_ADDR   = 6'h34;
	localparam logic [ADDR_W-1:0] MASK_ADDR     = 6'h38;
	localparam logic [ADDR_W-1:0] REVISION_ADDR = 6'h3C;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// per-timer control bits taken from the control word
	typedef struct packed {
		logic enable;
		logic slow_sel;
		logic ovf_en;
		logic count_up;
	} tmr_ctrl_t;

	// per-timer outcome of one tick item
	typedef struct packed {
		logic                   fire;
		logic [2:0]             st;
		logic [COUNT_WIDTH-1:0] count;
	} tmr_tick_t;

endpackage

`default_nettype wire

@@ sv/tmrt_req_if.sv @@
// ----------------------------------------------------------------------------
// tmrt_req_if: request channel of the timer block
// valid/ready handshake carrying one tick or bus access item
// ----------------------------------------------------------------------------
`default_nettype none

interface tmrt_req_if;
	import tmrt_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;
	logic              fast_tick;
	logic              slow_tick;

	modport source (output valid, output op, output address, output write_data,
		output fast_tick, output slow_tick, input ready);
	modport sink (input valid, input op, input address, input write_data,
		input fast_tick, input slow_tick, output ready);
endinterface

`default_nettype wire

@@ sv/tmrt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tmrt_rsp_if: response channel of the timer block
// valid/ready handshake carrying read data and interrupt pulses
// ----------------------------------------------------------------------------
`default_nettype none

interface tmrt_rsp_if;
	import tmrt_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic [IRQ_W-1:0]  irq_pulse;

	modport source (output valid, output read_data, output irq_pulse, input ready);
	modport sink (input valid, input read_data, input irq_pulse, output ready);
endinterface

`default_nettype wire

@@ sv/tmrt_unit.sv @@
// ----------------------------------------------------------------------------
// tmrt_unit: tick logic of one timer
// match compares, terminal detect, reload or count step, status bits
// ----------------------------------------------------------------------------
`default_nettype none

module tmrt_unit (
	input  wire logic                            tick,
	input  wire logic                            fast_tick,
	input  wire logic                            slow_tick,
	input  wire tmrt_pkg::tmr_ctrl_t             ctrl,
	input  wire logic [tmrt_pkg::COUNT_WIDTH-1:0] count,
	input  wire logic [tmrt_pkg::COUNT_WIDTH-1:0] reload,
	input  wire logic [tmrt_pkg::COUNT_WIDTH-1:0] match0,
	input  wire logic [tmrt_pkg::COUNT_WIDTH-1:0] match1,
	output tmrt_pkg::tmr_tick_t                  res
);
	import tmrt_pkg::*;

	logic                   src_tick;
	logic                   fire;
	logic                   at_term;
	logic [COUNT_WIDTH-1:0] term;

	assign src_tick = ctrl.slow_sel ? slow_tick : fast_tick;
	assign fire     = tick && ctrl.enable && src_tick;
	// all ones counting up, zero counting down
	assign term     = ctrl.count_up ? {COUNT_WIDTH{1'b1}} : '0;
	assign at_term  = (count == term);

	always_comb begin
		res.fire  = fire;
		res.st[0] = fire && (count == match0);
		res.st[1] = fire && (count == match1);
		res.st[2] = fire && at_term && ctrl.ovf_en;
		if (at_term) begin
			res.count = reload;
		end else if (ctrl.count_up) begin
			res.count = count + COUNT_WIDTH'(1);
		end else begin
			res.count = count - COUNT_WIDTH'(1);
		end
	end
endmodule

`default_nettype wire

@@ sv/triple_match_reload_timer_top.sv @@
// ----------------------------------------------------------------------------
// triple_match_reload_timer_top: three match/reload timers on a byte window
// tick items advance the timers, read/write items access the 64-byte window
// ----------------------------------------------------------------------------
// One item is taken per clock unless a stalled response holds the pipeline, and
// one response leaves per item, in order. An item passes an input register and
// then a result register, which holds its response until it is taken; all the
// timer and register work sits in one combinational pass between those two
// registers, so a new item can follow every cycle when no response stalls. A
// stalled response only holds the pipeline once both registers are full.
// Window map, timer t at 16*t: +0 counter, +4 reload,
// +8 match 0, +C match 1; 0x30 control (bit 3t enable, 3t+1 slow clock,
// 3t+2 overflow status enable, 9+t count up), 0x34 status (write one to
// clear; bit 3t match 0, 3t+1 match 1, 3t+2 overflow), 0x38 mask (plain
// storage), 0x3C revision (read only). Unmapped bytes read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module triple_match_reload_timer_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tmrt_req_if.sink    req,
	tmrt_rsp_if.source  rsp
);
	import tmrt_pkg::*;

	// register slot within a timer's 16-byte block
	localparam logic [1:0] SLOT_COUNT  = 2'd0;
	localparam logic [1:0] SLOT_RELOAD = 2'd1;
	localparam logic [1:0] SLOT_MATCH0 = 2'd2;
	localparam logic [1:0] SLOT_MATCH1 = 2'd3;

	function automatic logic [REG_W-1:0] put_byte(logic [REG_W-1:0] w, logic [1:0] lane,
		logic [DATA_W-1:0] d);
		logic [REG_W-1:0] r;
		r = w;
		r[{lane, 3'b000} +: DATA_W] = d;
		return r;
	endfunction

	// input register
	logic              valid_s1;
	logic [1:0]        op_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] wdata_s1;
	logic              fast_s1;
	logic              slow_s1;

	// result register
	logic              valid_s2;
	logic [DATA_W-1:0] rd_s2;
	logic [IRQ_W-1:0]  irq_s2;

	// timer state
	logic [COUNT_WIDTH-1:0] count_q  [NUM_TIMERS];
	logic [REG_W-1:0]       reload_q [NUM_TIMERS];
	logic [REG_W-1:0]       match_q  [2*NUM_TIMERS];
	logic [REG_W-1:0]       control_q;
	logic [REG_W-1:0]       status_q;
	logic [REG_W-1:0]       mask_q;

	logic adv;
	logic is_tick;
	logic is_read;
	logic is_write;
	logic in_timers;

	tmr_ctrl_t ctrl [NUM_TIMERS];
	tmr_tick_t tres [NUM_TIMERS];

	logic [COUNT_WIDTH-1:0] count_d  [NUM_TIMERS];
	logic [REG_W-1:0]       reload_d [NUM_TIMERS];
	logic [REG_W-1:0]       match_d  [2*NUM_TIMERS];
	logic [REG_W-1:0]       control_d;
	logic [REG_W-1:0]       status_d;
	logic [REG_W-1:0]       mask_d;
	logic [REG_W-1:0]       rd_word;
	logic [DATA_W-1:0]      rd_d;
	logic [IRQ_W-1:0]       irq_d;

	// handshake: stage 1 moves on when the result register is free or draining
	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign rsp.valid = valid_s2;
	assign rsp.read_data = rd_s2;
	assign rsp.irq_pulse = irq_s2;

	assign is_tick   = (op_s1 == OP_TICK);
	assign is_read   = (op_s1 == OP_READ);
	assign is_write  = (op_s1 == OP_WRITE);
	assign in_timers = (addr_s1 < CONTROL_ADDR);

	// per-timer tick logic
	for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_tmr
		assign ctrl[t].enable   = control_q[3*t];
		assign ctrl[t].slow_sel = control_q[3*t+1];
		assign ctrl[t].ovf_en   = control_q[3*t+2];
		assign ctrl[t].count_up = control_q[9+t];

		tmrt_unit u_unit (
			.tick      (is_tick),
			.fast_tick (fast_s1),
			.slow_tick (slow_s1),
			.ctrl      (ctrl[t]),
			.count     (count_q[t]),
			.reload    (reload_q[t][COUNT_WIDTH-1:0]),
			.match0    (match_q[2*t][COUNT_WIDTH-1:0]),
			.match1    (match_q[2*t+1][COUNT_WIDTH-1:0]),
			.res       (tres[t])
		);
	end

	// read word select
	always_comb begin
		rd_word = '0;
		if (addr_s1 >= REVISION_ADDR) begin
			rd_word = REVISION_WORD;
		end else if (!in_timers) begin
			unique case (addr_s1[3:2])
				CONTROL_ADDR[3:2]: rd_word = control_q;
				STATUS_ADDR[3:2]:  rd_word = status_q;
				MASK_ADDR[3:2]:    rd_word = mask_q;
				default:           rd_word = '0;
			endcase
		end else begin
			for (int t = 0; t < NUM_TIMERS; t++) begin
				if (addr_s1[5:4] == 2'(t)) begin
					unique case (addr_s1[3:2])
						SLOT_COUNT:  rd_word = REG_W'(count_q[t]);
						SLOT_RELOAD: rd_word = reload_q[t];
						SLOT_MATCH0: rd_word = match_q[2*t];
						SLOT_MATCH1: rd_word = match_q[2*t+1];
						default:     rd_word = '0;
					endcase
				end
			end
		end
		rd_d = is_read ? rd_word[{addr_s1[1:0], 3'b000} +: DATA_W] : '0;
	end

	// next state: a write hits one byte, a tick updates fired timers and status
	always_comb begin
		control_d = control_q;
		status_d  = status_q;
		mask_d    = mask_q;
		irq_d     = '0;
		for (int t = 0; t < NUM_TIMERS; t++) begin
			count_d[t]      = count_q[t];
			reload_d[t]     = reload_q[t];
			match_d[2*t]    = match_q[2*t];
			match_d[2*t+1]  = match_q[2*t+1];
			if (is_write && in_timers && addr_s1[5:4] == 2'(t)) begin
				unique case (addr_s1[3:2])
					SLOT_COUNT: count_d[t] = COUNT_WIDTH'(put_byte(REG_W'(count_q[t]),
						addr_s1[1:0], wdata_s1));
					SLOT_RELOAD: reload_d[t] = put_byte(reload_q[t], addr_s1[1:0], wdata_s1);
					SLOT_MATCH0: match_d[2*t] = put_byte(match_q[2*t], addr_s1[1:0],
						wdata_s1);
					SLOT_MATCH1: match_d[2*t+1] = put_byte(match_q[2*t+1], addr_s1[1:0],
						wdata_s1);
					default: ;
				endcase
			end
			if (tres[t].fire) begin
				count_d[t] = tres[t].count;
			end
			status_d[3*t +: 3] = status_d[3*t +: 3] | tres[t].st;
			irq_d[t]           = |tres[t].st;
		end
		if (is_write) begin
			if (addr_s1[5:2] == CONTROL_ADDR[5:2]) begin
				control_d = put_byte(control_q, addr_s1[1:0], wdata_s1);
			end
			if (addr_s1[5:2] == STATUS_ADDR[5:2]) begin
				// write one to clear
				status_d = status_q & ~put_byte('0, addr_s1[1:0], wdata_s1);
			end
			if (addr_s1[5:2] == MASK_ADDR[5:2]) begin
				mask_d = put_byte(mask_q, addr_s1[1:0], wdata_s1);
			end
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1    <= req.op;
			addr_s1  <= req.address;
			wdata_s1 <= req.write_data;
			fast_s1  <= req.fast_tick;
			slow_s1  <= req.slow_tick;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s2  <= rd_d;
			irq_s2 <= irq_d;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TIMERS; t++) begin
				count_q[t]       <= '0;
				reload_q[t]      <= '0;
				match_q[2*t]     <= '0;
				match_q[2*t+1]   <= '0;
			end
			control_q <= '0;
			status_q  <= '0;
			mask_q    <= '0;
		end else if (adv) begin
			for (int t = 0; t < NUM_TIMERS; t++) begin
				count_q[t]       <= count_d[t];
				reload_q[t]      <= reload_d[t];
				match_q[2*t]     <= match_d[2*t];
				match_q[2*t+1]   <= match_d[2*t+1];
			end
			control_q <= control_d;
			status_q  <= status_d;
			mask_q    <= mask_d;
		end
	end

	// a pending interrupt pulse always has a status bit still set
	a_irq_has_status: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && irq_s2 != '0) |-> (status_q != '0))
		else $error("irq pulse without status");

	// control and status move only when an item is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(control_q) && $stable(status_q)))
		else $error("state changed without an item");

	// only tick items raise interrupt pulses
	a_irq_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && op_s1 != OP_TICK) |=> (irq_s2 == '0))
		else $error("irq pulse on an access item");

endmodule

`default_nettype wire

@@ test/triple_match_reload_timer_checker.sv @@
// ----------------------------------------------------------------------------
// triple_match_reload_timer_checker: response predictor and comparator
// keeps its own copy of the timer registers, works out the response of every
// accepted item and compares it with the responses that leave the block
// ----------------------------------------------------------------------------
`default_nettype none

module triple_match_reload_timer_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	tmrt_req_if       req,
	tmrt_rsp_if       rsp,
	output int        failures,
	output int        outstanding
);
	import tmrt_pkg::*;

	localparam logic [REG_W-1:0] CNT_MASK = {REG_W{1'b1}} >> (REG_W - COUNT_WIDTH);

	// register slot of a timer, from address bits 3:2
	typedef enum logic [1:0] {
		REG_COUNT  = 2'd0,
		REG_RELOAD = 2'd1,
		REG_MATCH0 = 2'd2,
		REG_MATCH1 = 2'd3
	} timer_reg_e;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [IRQ_W-1:0]  irq_pulse;
	} timer_rsp_t;

	logic [REG_W-1:0] counter_reg [NUM_TIMERS];
	logic [REG_W-1:0] reload_reg [NUM_TIMERS];
	logic [REG_W-1:0] match_reg [2*NUM_TIMERS];
	logic [REG_W-1:0] control_reg;
	logic [REG_W-1:0] status_reg;
	logic [REG_W-1:0] mask_reg;

	timer_rsp_t expected_rsp [$];
	timer_rsp_t due;
	int         fail_total;

	function automatic logic [DATA_W-1:0] window_read(logic [ADDR_W-1:0] a);
		logic [REG_W-1:0] word;
		int               t;
		timer_reg_e       r;
		word = '0;
		t = int'(a[5:4]);
		r = timer_reg_e'(a[3:2]);
		if (a >= REVISION_ADDR) begin
			word = REVISION_WORD;
		end else if (a < CONTROL_ADDR) begin
			if (t < NUM_TIMERS) begin
				case (r)
					REG_COUNT:  word = counter_reg[t];
					REG_RELOAD: word = reload_reg[t];
					REG_MATCH0: word = match_reg[2*t];
					default:    word = match_reg[2*t+1];
				endcase
			end
		end else if (a < STATUS_ADDR) begin
			word = control_reg;
		end else if (a < MASK_ADDR) begin
			word = status_reg;
		end else begin
			word = mask_reg;
		end
		return word[8*a[1:0] +: DATA_W];
	endfunction

	function automatic void window_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
		int         t;
		int         sh;
		timer_reg_e r;
		t  = int'(a[5:4]);
		sh = 8*a[1:0];
		r  = timer_reg_e'(a[3:2]);
		if (a < CONTROL_ADDR) begin
			if (t < NUM_TIMERS) begin
				case (r)
					REG_COUNT: begin
						counter_reg[t][sh +: DATA_W] = d;
						counter_reg[t] &= CNT_MASK;
					end
					REG_RELOAD: reload_reg[t][sh +: DATA_W] = d;
					REG_MATCH0: match_reg[2*t][sh +: DATA_W] = d;
					default:    match_reg[2*t+1][sh +: DATA_W] = d;
				endcase
			end
		end else if (a < STATUS_ADDR) begin
			control_reg[sh +: DATA_W] = d;
		end else if (a < MASK_ADDR) begin
			// write one to clear
			status_reg[sh +: DATA_W] &= ~d;
		end else if (a < REVISION_ADDR) begin
			mask_reg[sh +: DATA_W] = d;
		end
	endfunction

	// advance every enabled timer whose selected clock ticked
	function automatic logic [IRQ_W-1:0] tick_timers(logic fast, logic slow);
		logic [IRQ_W-1:0] irq;
		logic [REG_W-1:0] cur;
		logic [REG_W-1:0] term;
		logic [2:0]       st;
		logic             up;
		logic             pulse;
		irq = '0;
		for (int t = 0; t < NUM_TIMERS; t++) begin
			up    = control_reg[9+t];
			pulse = control_reg[3*t+1] ? slow : fast;
			if (control_reg[3*t] && pulse) begin
				cur  = counter_reg[t] & CNT_MASK;
				term = up ? CNT_MASK : '0;
				st   = '0;
				if (cur == (match_reg[2*t] & CNT_MASK))
					st[0] = 1'b1;
				if (cur == (match_reg[2*t+1] & CNT_MASK))
					st[1] = 1'b1;
				if (cur == term) begin
					st[2] = control_reg[3*t+2];
					cur   = reload_reg[t] & CNT_MASK;
				end else begin
					cur = (up ? cur + 1'b1 : cur - 1'b1) & CNT_MASK;
				end
				counter_reg[t] = cur;
				if (st != '0) begin
					status_reg[3*t +: 3] |= st;
					irq[t] = 1'b1;
				end
			end
		end
		return irq;
	endfunction

	function automatic timer_rsp_t predict_response(op_t op, logic [ADDR_W-1:0] a,
			logic [DATA_W-1:0] d, logic fast, logic slow);
		timer_rsp_t r;
		r = '0;
		case (op)
			OP_TICK:  r.irq_pulse = tick_timers(fast, slow);
			OP_READ:  r.read_data = window_read(a);
			OP_WRITE: window_write(a, d);
			default:  ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TIMERS; t++) begin
				counter_reg[t]   = '0;
				reload_reg[t]    = '0;
				match_reg[2*t]   = '0;
				match_reg[2*t+1] = '0;
			end
			control_reg = '0;
			status_reg  = '0;
			mask_reg    = '0;
			expected_rsp.delete();
			fail_total  = 0;
			failures    <= 0;
			outstanding <= 0;
		end else begin
			// responses belong to earlier items, so compare before predicting
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					$error("unexpected response: read_data %02h irq_pulse %01h",
						rsp.read_data, rsp.irq_pulse);
					fail_total++;
				end else begin
					due = expected_rsp.pop_front();
					if (rsp.read_data !== due.read_data) begin
						$error("read_data: expected %02h, got %02h",
							due.read_data, rsp.read_data);
						fail_total++;
					end
					if (rsp.irq_pulse !== due.irq_pulse) begin
						$error("irq_pulse: expected %01h, got %01h",
							due.irq_pulse, rsp.irq_pulse);
						fail_total++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_rsp.push_back(predict_response(op_t'(req.op), req.address,
					req.write_data, req.fast_tick, req.slow_tick));
			failures    <= fail_total;
			outstanding <= expected_rsp.size();
		end
	end

endmodule

`default_nettype wire

@@ test/triple_match_reload_timer_top_tb.sv @@
// ----------------------------------------------------------------------------
// triple_match_reload_timer_top_tb: testbench of the triple timer block
// drives directed and random tick/access items with random gaps and response
// stalls; a checker beside the block predicts and compares every response
// ----------------------------------------------------------------------------
`default_nettype none

module triple_match_reload_timer_top_tb;
	import tmrt_pkg::*;

	localparam int RANDOM_ITEMS = 1750;
	localparam int IDLE_LIMIT   = 4000; // cycles with no handshake on either side
	localparam int DRAIN_CYCLES = 10;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   burst_left;

	tmrt_req_if req_ch ();
	tmrt_rsp_if rsp_ch ();

	triple_match_reload_timer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	triple_match_reload_timer_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.failures    (fail_count),
		.outstanding (pending)
	);

	always #10 clk = ~clk;

	// sender gap: mostly none or short, now and then long, with bursts of
	// back-to-back items so the pipeline also runs full
	function automatic int idle_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			burst_left = $urandom_range(20, 100);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// present one item at a falling edge and hold it until it is taken;
	// valid stays high on return so a following item can go out back to back
	task automatic send_item(op_t op, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
			logic fast, logic slow);
		int gap;
		gap = idle_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.op         <= op;
		req_ch.address    <= a;
		req_ch.write_data <= d;
		req_ch.fast_tick  <= fast;
		req_ch.slow_tick  <= slow;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// random item; writes favour small counter bytes and the control word
	// so that timers run, match, wrap and reload often
	task automatic send_random_item(output bit counted);
		int                pick;
		op_t               op;
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] d;
		logic              fast;
		logic              slow;
		pick = $urandom_range(0, 99);
		a    = ADDR_W'($urandom_range(0, 63));
		d    = DATA_W'($urandom_range(0, 255));
		fast = ($urandom_range(0, 3) != 0);
		slow = 1'($urandom_range(0, 1));
		if (pick < 55)
			op = OP_TICK;
		else if (pick < 77)
			op = OP_WRITE;
		else if (pick < 95)
			op = OP_READ;
		else
			op = OP_NONE;
		if (op == OP_WRITE) begin
			pick = $urandom_range(0, 9);
			if (pick < 2)
				a = CONTROL_ADDR + ADDR_W'($urandom_range(0, 1));
			else if (pick < 3)
				a = STATUS_ADDR + ADDR_W'($urandom_range(0, 1));
			if (a < CONTROL_ADDR) begin
				pick = $urandom_range(0, 9);
				if (a[1:0] == 2'd0) begin
					// low byte: small start values or values near a wrap
					if (pick < 4)
						d = DATA_W'($urandom_range(0, 7));
					else if (pick < 6)
						d = DATA_W'($urandom_range(8'hF8, 8'hFF));
				end else begin
					// upper bytes: mostly zero, sometimes all ones for count-up wraps
					if (pick < 7)
						d = 8'h00;
					else if (pick < 9)
						d = 8'hFF;
				end
			end
		end
		counted = (op != OP_NONE);
		send_item(op, a, d, fast, slow);
	endtask

	// response side: ready high for runs, low for short and now and then long stalls
	initial begin
		int r;
		int hold;
		rsp_ch.ready = 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				rsp_ch.ready <= 1'b1;
				hold = $urandom_range(1, 20);
			end else begin
				rsp_ch.ready <= 1'b0;
				if (r < 90)
					hold = $urandom_range(1, 3);
				else if (r < 97)
					hold = $urandom_range(4, 12);
				else
					hold = $urandom_range(30, 80);
			end
			repeat (hold) @(negedge clk);
		end
	end

	// watchdog: a stuck handshake ends the run
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		int useful;
		bit counted;
		arst_n            = 1'b0;
		burst_left        = 0;
		req_ch.valid      = 1'b0;
		req_ch.op         = OP_TICK;
		req_ch.address    = '0;
		req_ch.write_data = '0;
		req_ch.fast_tick  = 1'b0;
		req_ch.slow_tick  = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// revision word: read only, tick bits on reads are ignored
		send_item(OP_READ, REVISION_ADDR, 8'h00, 1'b1, 1'b1);
		send_item(OP_READ, REVISION_ADDR + 6'd3, 8'hFF, 1'b0, 1'b1);
		send_item(OP_WRITE, REVISION_ADDR, 8'hFF, 1'b1, 1'b0);
		send_item(OP_WRITE, 6'h3F, 8'h00, 1'b0, 1'b0);
		send_item(OP_READ, REVISION_ADDR, 8'h00, 1'b0, 1'b0);

		// timer 0: counts down from 2, match 0 at 1, reload to the top byte
		send_item(OP_WRITE, 6'h00, 8'h02, 1'b0, 1'b0);
		send_item(OP_WRITE, 6'h08, 8'h01, 1'b0, 1'b0);
		send_item(OP_WRITE, 6'h07, 8'hFF, 1'b0, 1'b0);

		// timer 1: all ones, counting up on the slow clock, so it wraps at once
		send_item(OP_WRITE, 6'h10, 8'hFF, 1'b0, 1'b0);
		send_item(OP_WRITE, 6'h11, 8'hFF, 1'b0, 1'b0);
		send_item(OP_WRITE, 6'h12, 8'hFF, 1'b0, 1'b0);
		send_item(OP_WRITE, 6'h13, 8'hFF, 1'b0, 1'b0);

		// enable timers 0 and 1 with overflow status, timer 1 on slow clock, counting up
		send_item(OP_WRITE, CONTROL_ADDR, 8'h3D, 1'b0, 1'b0);
		send_item(OP_WRITE, CONTROL_ADDR + 6'd1, 8'h04, 1'b0, 1'b0);

		// fast only, both clocks (match 0 and up-count wrap), slow only, then
		// timer 0 at zero hits match 1 and overflows in one tick
		send_item(OP_TICK, 6'h00, 8'h00, 1'b1, 1'b0);
		send_item(OP_TICK, 6'h3F, 8'hFF, 1'b1, 1'b1);
		send_item(OP_TICK, 6'h00, 8'h00, 1'b0, 1'b1);
		send_item(OP_TICK, 6'h00, 8'h00, 1'b1, 1'b0);

		// status bits, then clear them by writing ones
		send_item(OP_READ, STATUS_ADDR, 8'h00, 1'b0, 1'b0);
		send_item(OP_READ, STATUS_ADDR + 6'd1, 8'h00, 1'b0, 1'b0);
		send_item(OP_WRITE, STATUS_ADDR, 8'hFF, 1'b0, 1'b0);
		send_item(OP_READ, STATUS_ADDR, 8'h00, 1'b0, 1'b0);

		// mask is plain storage
		send_item(OP_WRITE, MASK_ADDR, 8'hA5, 1'b0, 1'b0);
		send_item(OP_READ, MASK_ADDR, 8'h00, 1'b0, 1'b0);

		// unused op code changes nothing
		send_item(OP_NONE, 6'h3F, 8'hFF, 1'b1, 1'b1);

		useful = 0;
		while (useful < RANDOM_ITEMS) begin
			send_random_item(counted);
			if (counted)
				useful++;
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		// catch any stray response after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
